// ----- sv/ccs_pkg.sv -----
// Shared types, register indexes and constants of the closest-row scan block.
`timescale 1ns / 1ps

package ccs_pkg;

    // Coefficient and curve value width (signed fixed point)
    localparam int COEF_W = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ROW_W  = 12;
    localparam int LIMIT_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ROW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

    localparam logic [CFG_ROW_W-1:0] START_ROW_RST = 12'd800;
    localparam logic [CFG_ROW_W-1:0] END_ROW_RST   = 12'd600;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST     = 16'd1000;

    // Three multiply/add pairs, then one difference stage
    localparam int HORNER_LAT = 6;
    localparam int PIPE_DEPTH = HORNER_LAT + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } ccs_state_t;

    typedef struct packed {
        logic start;     // capture coefficients, clear best, load first row
        logic issue;     // push current row into the pipeline
        logic load_out;  // move best match into the output register
    } ccs_cmd_t;

    typedef struct packed {
        logic empty_scan;  // start row below end row
        logic at_last;     // row counter sits on the end row
        logic pipe_busy;   // some row still in flight
        logic out_free;    // output register can take a result this cycle
    } ccs_sts_t;

endpackage

// ----- sv/ccs_horner.sv -----
// Pipelined Horner evaluation of one cubic curve, one row per cycle.
`timescale 1ns / 1ps

module ccs_horner #(
    parameter int ROW_BITS = 12
) (
    input  logic                                clk,
    input  logic signed [ccs_pkg::COEF_W-1:0]   coef_cubic,
    input  logic signed [ccs_pkg::COEF_W-1:0]   coef_square,
    input  logic signed [ccs_pkg::COEF_W-1:0]   coef_linear,
    input  logic signed [ccs_pkg::COEF_W-1:0]   coef_offset,
    input  logic        [ROW_BITS-1:0]          row_in,
    output logic signed [ccs_pkg::COEF_W-1:0]   x
);

    localparam int CW = ccs_pkg::COEF_W;
    localparam int PW = CW + ROW_BITS + 1;

    localparam logic signed [CW-1:0] VAL_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] VAL_MIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [PW-1:0] mul_row(
        input logic signed [CW-1:0]       a,
        input logic        [ROW_BITS-1:0] r
    );
        logic signed [PW-1:0] ae;
        logic signed [PW-1:0] re;
        ae = PW'(a);
        re = $signed(PW'(r));
        return ae * re;
    endfunction

    function automatic logic signed [CW-1:0] clamp_prod(input logic signed [PW-1:0] p);
        logic fits;
        fits = (p[PW-1:CW-1] == {(PW-CW+1){p[PW-1]}});
        if (fits)
            return p[CW-1:0];
        else if (p[PW-1])
            return VAL_MIN;
        else
            return VAL_MAX;
    endfunction

    function automatic logic signed [CW-1:0] sat_add(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1])
            return s[CW] ? VAL_MIN : VAL_MAX;
        return s[CW-1:0];
    endfunction

    logic signed [PW-1:0]     prod1_reg, prod1_next;
    logic signed [PW-1:0]     prod2_reg, prod2_next;
    logic signed [PW-1:0]     prod3_reg, prod3_next;
    logic signed [CW-1:0]     acc1_reg, acc1_next;
    logic signed [CW-1:0]     acc2_reg, acc2_next;
    logic signed [CW-1:0]     x_reg, x_next;
    logic        [ROW_BITS-1:0] row1_reg, row2_reg, row3_reg, row4_reg;

    // Multiply stages take the row that travels alongside; add stages saturate twice
    always_comb
    begin
        prod1_next = mul_row(coef_cubic, row_in);
        acc1_next  = sat_add(clamp_prod(prod1_reg), coef_square);
        prod2_next = mul_row(acc1_reg, row2_reg);
        acc2_next  = sat_add(clamp_prod(prod2_reg), coef_linear);
        prod3_next = mul_row(acc2_reg, row4_reg);
        x_next     = sat_add(clamp_prod(prod3_reg), coef_offset);
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        acc1_reg  <= acc1_next;
        prod2_reg <= prod2_next;
        acc2_reg  <= acc2_next;
        prod3_reg <= prod3_next;
        x_reg     <= x_next;
        row1_reg  <= row_in;
        row2_reg  <= row1_reg;
        row3_reg  <= row2_reg;
        row4_reg  <= row3_reg;
    end

    assign x = x_reg;

endmodule

// ----- sv/ccs_datapath.sv -----
// Datapath: configuration registers, row counter, curve pipelines, best match, output register.
`timescale 1ns / 1ps

module ccs_datapath #(
    parameter int ROW_BITS  = 12,
    parameter int FRAC_BITS = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ccs_pkg::ccs_cmd_t                     cmd,
    output ccs_pkg::ccs_sts_t                     sts,
    input  logic                                  cfg_valid,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [ccs_pkg::COEF_W-1:0]     first_cubic,
    input  logic signed [ccs_pkg::COEF_W-1:0]     first_square,
    input  logic signed [ccs_pkg::COEF_W-1:0]     first_linear,
    input  logic signed [ccs_pkg::COEF_W-1:0]     first_offset,
    input  logic signed [ccs_pkg::COEF_W-1:0]     second_cubic,
    input  logic signed [ccs_pkg::COEF_W-1:0]     second_square,
    input  logic signed [ccs_pkg::COEF_W-1:0]     second_linear,
    input  logic signed [ccs_pkg::COEF_W-1:0]     second_offset,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic                                  found,
    output logic signed [ccs_pkg::COEF_W-1:0]     meet_x,
    output logic        [ROW_BITS-1:0]            meet_row
);

    localparam int CW    = ccs_pkg::COEF_W;
    localparam int DEPTH = ccs_pkg::PIPE_DEPTH;

    // Configuration registers
    logic [ccs_pkg::CFG_ROW_W-1:0] start_row_reg, start_row_next;
    logic [ccs_pkg::CFG_ROW_W-1:0] end_row_reg, end_row_next;
    logic [ccs_pkg::LIMIT_W-1:0]   limit_reg, limit_next;

    // Coefficients held for the whole scan
    logic signed [CW-1:0] c1_cubic_reg, c1_square_reg, c1_linear_reg, c1_offset_reg;
    logic signed [CW-1:0] c2_cubic_reg, c2_square_reg, c2_linear_reg, c2_offset_reg;

    logic [ROW_BITS-1:0] first_row;
    logic [ROW_BITS-1:0] last_row;
    logic [ROW_BITS-1:0] row_reg, row_next;

    logic [DEPTH-1:0]    valid_pipe_reg, valid_pipe_next;
    logic [ROW_BITS-1:0] row_pipe_reg [DEPTH];

    logic signed [CW-1:0] x1, x2;
    logic signed [CW:0]   diff_wide;
    logic signed [CW:0]   sum_wide;
    logic [CW-1:0]        diff_reg, diff_next;
    logic signed [CW-1:0] mean_reg, mean_next;

    logic                 found_reg, found_next;
    logic [CW-1:0]        best_d_reg, best_d_next;
    logic signed [CW-1:0] best_x_reg, best_x_next;
    logic [ROW_BITS-1:0]  best_row_reg, best_row_next;
    logic                 take;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg;
    logic signed [CW-1:0] out_x_reg;
    logic [ROW_BITS-1:0]  out_row_reg;

    assign first_row = ROW_BITS'(start_row_reg);
    assign last_row  = ROW_BITS'(end_row_reg);

    always_comb
    begin
        start_row_next = start_row_reg;
        end_row_next   = end_row_reg;
        limit_next     = limit_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ccs_pkg::CFG_START_ROW: start_row_next = cfg_data[ccs_pkg::CFG_ROW_W-1:0];
                ccs_pkg::CFG_END_ROW:   end_row_next   = cfg_data[ccs_pkg::CFG_ROW_W-1:0];
                ccs_pkg::CFG_LIMIT:     limit_next     = cfg_data[ccs_pkg::LIMIT_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= ccs_pkg::START_ROW_RST;
            end_row_reg   <= ccs_pkg::END_ROW_RST;
            limit_reg     <= ccs_pkg::LIMIT_RST;
        end
        else
        begin
            start_row_reg <= start_row_next;
            end_row_reg   <= end_row_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            c1_cubic_reg  <= first_cubic;
            c1_square_reg <= first_square;
            c1_linear_reg <= first_linear;
            c1_offset_reg <= first_offset;
            c2_cubic_reg  <= second_cubic;
            c2_square_reg <= second_square;
            c2_linear_reg <= second_linear;
            c2_offset_reg <= second_offset;
        end
    end

    // Row counter: count down, hold on the end row so row zero never wraps
    always_comb
    begin
        if (cmd.start)
            row_next = first_row;
        else if (cmd.issue && !sts.at_last)
            row_next = row_reg - 1'b1;
        else
            row_next = row_reg;
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign valid_pipe_next = {valid_pipe_reg[DEPTH-2:0], cmd.issue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_pipe_reg <= '0;
        else
            valid_pipe_reg <= valid_pipe_next;
    end

    always_ff @(posedge clk)
    begin
        row_pipe_reg[0] <= row_reg;
        for (int i = 1; i < DEPTH; i++)
            row_pipe_reg[i] <= row_pipe_reg[i-1];
    end

    ccs_horner #(
        .ROW_BITS (ROW_BITS)
    ) u_horner_first (
        .clk         (clk),
        .coef_cubic  (c1_cubic_reg),
        .coef_square (c1_square_reg),
        .coef_linear (c1_linear_reg),
        .coef_offset (c1_offset_reg),
        .row_in      (row_reg),
        .x           (x1)
    );

    ccs_horner #(
        .ROW_BITS (ROW_BITS)
    ) u_horner_second (
        .clk         (clk),
        .coef_cubic  (c2_cubic_reg),
        .coef_square (c2_square_reg),
        .coef_linear (c2_linear_reg),
        .coef_offset (c2_offset_reg),
        .row_in      (row_reg),
        .x           (x2)
    );

    // Exact magnitude of the difference and floor of the mean
    always_comb
    begin
        diff_wide = {x1[CW-1], x1} - {x2[CW-1], x2};
        sum_wide  = {x1[CW-1], x1} + {x2[CW-1], x2};
        diff_next = diff_wide[CW] ? CW'(-diff_wide) : diff_wide[CW-1:0];
        mean_next = sum_wide[CW:1];
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        mean_reg <= mean_next;
    end

    // Strictly smaller wins, so the earliest scanned row keeps a tie
    always_comb
    begin
        if (found_reg)
            take = (diff_reg < best_d_reg);
        else
            take = ((diff_reg >> FRAC_BITS) < CW'(limit_reg));

        found_next    = found_reg;
        best_d_next   = best_d_reg;
        best_x_next   = best_x_reg;
        best_row_next = best_row_reg;
        if (cmd.start)
        begin
            found_next    = 1'b0;
            best_x_next   = '0;
            best_row_next = '0;
        end
        else if (valid_pipe_reg[DEPTH-1] && take)
        begin
            found_next    = 1'b1;
            best_d_next   = diff_reg;
            best_x_next   = mean_reg;
            best_row_next = row_pipe_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg    <= found_next;
        best_d_reg   <= best_d_next;
        best_x_reg   <= best_x_next;
        best_row_reg <= best_row_next;
    end

    // Output register: hold while stalled, drop once taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_found_reg <= found_reg;
            out_x_reg     <= best_x_reg;
            out_row_reg   <= best_row_reg;
        end
    end

    assign sts.empty_scan = (first_row < last_row);
    assign sts.at_last    = (row_reg == last_row);
    assign sts.pipe_busy  = |valid_pipe_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign meet_x    = out_x_reg;
    assign meet_row  = out_row_reg;

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load did not raise out_valid");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (row_reg >= last_row))
        else $error("row issued below the end row");

    a_row_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && !sts.at_last) |=> (row_reg == $past(row_reg) - 1'b1))
        else $error("row counter did not step down by one");

endmodule

// ----- sv/ccs_ctrl.sv -----
// Controller: accepts an item, sequences the row scan, drains and hands off the result.
`timescale 1ns / 1ps

module ccs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ccs_pkg::ccs_sts_t sts,
    output ccs_pkg::ccs_cmd_t cmd
);

    ccs_pkg::ccs_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ccs_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = sts.empty_scan ? ccs_pkg::ST_DRAIN : ccs_pkg::ST_SCAN;
            end
            ccs_pkg::ST_SCAN:
            begin
                if (sts.at_last)
                    state_next = ccs_pkg::ST_DRAIN;
            end
            ccs_pkg::ST_DRAIN:
            begin
                if (!sts.pipe_busy && sts.out_free)
                    state_next = ccs_pkg::ST_IDLE;
            end
            default:
                state_next = ccs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ccs_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            ccs_pkg::ST_SCAN:
                cmd.issue = 1'b1;
            ccs_pkg::ST_DRAIN:
                cmd.load_out = !sts.pipe_busy && sts.out_free;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ccs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ccs_pkg::ST_IDLE) |-> !sts.pipe_busy)
        else $error("rows still in flight while idle");

endmodule

// ----- sv/cubic_curve_closest_row_scan_core.sv -----
// Top level of the closest-row scan between two cubic curves.
// A transaction scans N = start_row - end_row + 1 rows, and none when start_row is below
//   end_row. The next transaction is taken once the pipeline has drained and the result
//   has moved to the output register; one row per cycle enters the 7-stage pipeline
//   (three multiply/saturating-add pairs per curve, one difference).
// Reset: registers return to start_row 800, end_row 600, distance_limit 1000;
//   the controller goes idle and no result is held.
`timescale 1ns / 1ps

module cubic_curve_closest_row_scan_core #(
    parameter int ROW_BITS  = 12,
    parameter int FRAC_BITS = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]        cfg_data,

    // Input channel: both curves
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ccs_pkg::COEF_W-1:0]     first_cubic,
    input  logic signed [ccs_pkg::COEF_W-1:0]     first_square,
    input  logic signed [ccs_pkg::COEF_W-1:0]     first_linear,
    input  logic signed [ccs_pkg::COEF_W-1:0]     first_offset,
    input  logic signed [ccs_pkg::COEF_W-1:0]     second_cubic,
    input  logic signed [ccs_pkg::COEF_W-1:0]     second_square,
    input  logic signed [ccs_pkg::COEF_W-1:0]     second_linear,
    input  logic signed [ccs_pkg::COEF_W-1:0]     second_offset,

    // Output channel: best row
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  found,
    output logic signed [ccs_pkg::COEF_W-1:0]     meet_x,
    output logic        [ROW_BITS-1:0]            meet_row
);

    ccs_pkg::ccs_cmd_t cmd;
    ccs_pkg::ccs_sts_t sts;

    // Registers take a write in any cycle; the contract keeps writes to idle periods.
    assign cfg_ready = 1'b1;

    // The controller walks the rows: it captures the coefficients, issues each
    // row in turn, then it waits for the pipeline to empty and
    // for the output register to be free before it takes the next transaction.
    ccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the row counter, both curve pipelines,
    // the running best match and the output register. A finished result waits
    // in the output register while the next transaction is already scanning.
    ccs_datapath #(
        .ROW_BITS  (ROW_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .first_cubic   (first_cubic),
        .first_square  (first_square),
        .first_linear  (first_linear),
        .first_offset  (first_offset),
        .second_cubic  (second_cubic),
        .second_square (second_square),
        .second_linear (second_linear),
        .second_offset (second_offset),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .found         (found),
        .meet_x        (meet_x),
        .meet_row      (meet_row)
    );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the closest-row scan between two cubic curves.
`timescale 1ns / 1ps

module tb;

    localparam int COEF_W     = ccs_pkg::COEF_W;
    localparam int CFG_IDX_W  = ccs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ccs_pkg::CFG_DATA_W;
    localparam int CFG_ROW_W  = ccs_pkg::CFG_ROW_W;
    localparam int LIMIT_W    = ccs_pkg::LIMIT_W;

    localparam int ROW_W  = 12;
    localparam int FRAC   = 48;
    localparam int RANDOM_ITEMS = 1450;
    // Watchdog bound on the whole run, well above the slowest legal run.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Quiet cycles after the last result.
    localparam int SETTLE_CYCLES = 32;

    localparam logic signed [COEF_W-1:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [COEF_W-1:0] S_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [COEF_W-1:0] ONE_PX = 64'sh0001_0000_0000_0000;

    typedef struct {
        logic signed [COEF_W-1:0] cubic;
        logic signed [COEF_W-1:0] square;
        logic signed [COEF_W-1:0] linear;
        logic signed [COEF_W-1:0] offset;
    } curve_t;

    typedef struct {
        curve_t first;
        curve_t second;
    } curve_pair_t;

    typedef struct {
        logic                     found;
        logic signed [COEF_W-1:0] x;
        logic [ROW_W-1:0]         row;
    } meet_t;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [COEF_W-1:0] first_cubic;
    logic signed [COEF_W-1:0] first_square;
    logic signed [COEF_W-1:0] first_linear;
    logic signed [COEF_W-1:0] first_offset;
    logic signed [COEF_W-1:0] second_cubic;
    logic signed [COEF_W-1:0] second_square;
    logic signed [COEF_W-1:0] second_linear;
    logic signed [COEF_W-1:0] second_offset;
    logic                     out_valid;
    logic                     out_stall;
    logic                     found;
    logic signed [COEF_W-1:0] meet_x;
    logic [ROW_W-1:0]         meet_row;

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    // Mirror of the scan registers, updated on each accepted config write.
    logic [ROW_W-1:0]   scan_top    = ccs_pkg::START_ROW_RST;
    logic [ROW_W-1:0]   scan_bottom = ccs_pkg::END_ROW_RST;
    logic [LIMIT_W-1:0] limit_px    = ccs_pkg::LIMIT_RST;

    meet_t pending_meets[$];   // expected results, oldest first
    int    mismatch_count = 0;
    int    meets_checked  = 0;
    int    cycle_count    = 0;
    bit    tx_idle_on     = 1'b1;
    bit    rx_idle_on     = 1'b1;
    int    rx_holdoff_req = 0;  // one-shot long stall for the result side

    cubic_curve_closest_row_scan_core #(
        .ROW_BITS  (ROW_W),
        .FRAC_BITS (FRAC)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_cubic   (first_cubic),
        .first_square  (first_square),
        .first_linear  (first_linear),
        .first_offset  (first_offset),
        .second_cubic  (second_cubic),
        .second_square (second_square),
        .second_linear (second_linear),
        .second_offset (second_offset),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .meet_x        (meet_x),
        .meet_row      (meet_row)
    );

    // ------------------------------------------------------------------
    // Scan predictor: saturating Horner evaluation over the row range
    // ------------------------------------------------------------------
    function automatic logic signed [79:0] widen(logic signed [COEF_W-1:0] v);
        return {{16{v[COEF_W-1]}}, v};
    endfunction

    // Clamp a wide value to the signed 64-bit range.
    function automatic logic signed [COEF_W-1:0] saturate(logic signed [79:0] v);
        if (v[79:63] == {17{v[79]}})
            return v[63:0];
        return v[79] ? S_MIN : S_MAX;
    endfunction

    // One Horner step: acc * row, clamp, add coefficient, clamp.
    function automatic logic signed [COEF_W-1:0] horner_step(
        logic signed [COEF_W-1:0] acc,
        logic [ROW_W-1:0]         r,
        logic signed [COEF_W-1:0] coef
    );
        logic signed [79:0] prod;
        prod = widen(acc) * $signed({68'd0, r});
        return saturate(widen(saturate(prod)) + widen(coef));
    endfunction

    function automatic logic signed [COEF_W-1:0] eval_curve(curve_t c, logic [ROW_W-1:0] r);
        logic signed [COEF_W-1:0] acc;
        acc = horner_step(c.cubic, r, c.square);
        acc = horner_step(acc, r, c.linear);
        return horner_step(acc, r, c.offset);
    endfunction

    function automatic meet_t scan_closest_row(curve_pair_t p);
        meet_t                    best;
        logic [COEF_W-1:0]        best_gap;
        logic [COEF_W-1:0]        gap;
        logic signed [79:0]       delta;
        logic signed [79:0]       sum;
        logic signed [COEF_W-1:0] x1;
        logic signed [COEF_W-1:0] x2;
        logic [ROW_W-1:0]         r;
        logic                     last_row;
        best.found = 1'b0;
        best.x     = '0;
        best.row   = '0;
        best_gap   = '0;
        // Start below end scans nothing; the walk never wraps below row 0.
        if (scan_top >= scan_bottom)
        begin
            r = scan_top;
            do
            begin
                x1 = eval_curve(p.first, r);
                x2 = eval_curve(p.second, r);
                delta = widen(x1) - widen(x2);
                if (delta < 0)
                    delta = -delta;
                gap = delta[63:0];
                // Strictly smaller wins, so the higher row keeps a tie.
                if (best.found ? (gap < best_gap)
                               : ((gap >> FRAC) < 64'(limit_px)))
                begin
                    sum        = widen(x1) + widen(x2);
                    best.found = 1'b1;
                    best_gap   = gap;
                    best.x     = sum[64:1];   // floor of the exact mean
                    best.row   = r;
                end
                last_row = (r == scan_bottom);
                r = r - 1'b1;
            end
            while (!last_row);
        end
        return best;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Random value of up to the given magnitude width, random sign.
    function automatic logic signed [COEF_W-1:0] rand_mag(int bits);
        logic [COEF_W-1:0] v;
        v = {$urandom, $urandom};
        if (bits < 64)
            v &= (64'd1 << bits) - 64'd1;
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic signed [COEF_W-1:0] px(int n);
        return 64'(n) << FRAC;
    endfunction

    function automatic curve_pair_t make_pair(
        logic signed [COEF_W-1:0] a3, logic signed [COEF_W-1:0] a2,
        logic signed [COEF_W-1:0] a1, logic signed [COEF_W-1:0] a0,
        logic signed [COEF_W-1:0] b3, logic signed [COEF_W-1:0] b2,
        logic signed [COEF_W-1:0] b1, logic signed [COEF_W-1:0] b0
    );
        curve_pair_t p;
        p.first  = '{a3, a2, a1, a0};
        p.second = '{b3, b2, b1, b0};
        return p;
    endfunction

    // Plausible curve plus a nearby one, so the pair often meets in range.
    function automatic curve_pair_t crossing_pair();
        curve_pair_t p;
        p.first.cubic   = rand_mag(30);
        p.first.square  = rand_mag(40);
        p.first.linear  = rand_mag(50);
        p.first.offset  = px($urandom_range(0, 1900)) + rand_mag(47);
        p.second.cubic  = p.first.cubic  + rand_mag($urandom_range(0, 26));
        p.second.square = p.first.square + rand_mag($urandom_range(0, 36));
        p.second.linear = p.first.linear + rand_mag($urandom_range(0, 47));
        p.second.offset = p.first.offset + rand_mag($urandom_range(40, 57));
        return p;
    endfunction

    // Same shape, shifted: every row ties.
    function automatic curve_pair_t shifted_pair();
        curve_pair_t p;
        p = crossing_pair();
        p.second = p.first;
        p.second.offset = p.first.offset + rand_mag($urandom_range(0, 52));
        return p;
    endfunction

    function automatic logic signed [COEF_W-1:0] noise_coef();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            default: return rand_mag($urandom_range(0, 64));
        endcase
    endfunction

    function automatic curve_pair_t noise_pair();
        curve_pair_t p;
        p.first  = '{noise_coef(), noise_coef(), noise_coef(), noise_coef()};
        p.second = '{noise_coef(), noise_coef(), noise_coef(), noise_coef()};
        return p;
    endfunction

    function automatic curve_pair_t random_pair();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
            return crossing_pair();
        if (pick == 7)
            return shifted_pair();
        return noise_pair();
    endfunction

    // ------------------------------------------------------------------
    // Transaction tasks
    // ------------------------------------------------------------------
    // Offer one curve pair; hold it until accepted, then idle a random gap.
    // Valid stays high across back-to-back items.
    task automatic send_pair(curve_pair_t p);
        int gap;
        first_cubic   <= p.first.cubic;
        first_square  <= p.first.square;
        first_linear  <= p.first.linear;
        first_offset  <= p.first.offset;
        second_cubic  <= p.second.cubic;
        second_square <= p.second.square;
        second_linear <= p.second.linear;
        second_offset <= p.second.offset;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_meets.insert(pending_meets.size(), scan_closest_row(p));
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_meets.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; valid stays high for the caller to chain writes.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ccs_pkg::CFG_START_ROW: scan_top    = data[CFG_ROW_W-1:0];
            ccs_pkg::CFG_END_ROW:   scan_bottom = data[CFG_ROW_W-1:0];
            ccs_pkg::CFG_LIMIT:     limit_px    = data[LIMIT_W-1:0];
            default:                ;
        endcase
    endtask

    // Reprogram all three registers once the block has gone idle.
    task automatic set_scan(
        logic [CFG_DATA_W-1:0] top_word,
        logic [CFG_DATA_W-1:0] bottom_word,
        logic [CFG_DATA_W-1:0] limit_word
    );
        drain_results();
        write_reg(ccs_pkg::CFG_START_ROW, top_word);
        write_reg(ccs_pkg::CFG_END_ROW, bottom_word);
        write_reg(ccs_pkg::CFG_LIMIT, limit_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s at result %0d: got %h, want %h",
                 field, meets_checked, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values 800 down to 600, limit 1000: no config write yet.
    task automatic test_reset_defaults();
        send_pair(crossing_pair());
        // Far apart: nothing qualifies, all result fields zero.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, px(5000)));
        // x = r meets the constant 700 exactly at row 700.
        send_pair(make_pair(0, 0, ONE_PX, 0, 0, 0, 0, px(700)));
    endtask

    task automatic test_ties_and_midpoint();
        curve_pair_t p;
        // Garbage in the upper data bits; only the low row bits count.
        set_scan(16'hF00A, 16'h5003, 16'd1000);
        p = crossing_pair();
        p.second = p.first;
        send_pair(p);                 // zero gap everywhere: top row wins
        send_pair(shifted_pair());    // constant gap: top row wins
        // Midpoint rounds toward minus infinity.
        send_pair(make_pair(0, 0, 0, -64'sd1, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 64'sd3, 0, 0, 0, 0));
        // x = r against 6.5 px: rows 7 and 6 tie, row 7 is kept.
        send_pair(make_pair(0, 0, ONE_PX, 0, 0, 0, 0, px(6) + (ONE_PX >>> 1)));
    endtask

    task automatic test_saturation();
        set_scan(16'd20, 16'd0, 16'hFFFF);
        // Full-range gap of 2^64-1 fails even the widest limit.
        send_pair(make_pair(S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN));
        // Gap of 2^63-1 qualifies under the widest limit.
        send_pair(make_pair(0, 0, 0, S_MAX, 0, 0, 0, 0));
        // Opposite rails everywhere but row 0, where both are zero.
        send_pair(make_pair(S_MIN, 0, 0, 0, S_MAX, 0, 0, 0));
        // Product clamps high, then the sum pulls it back.
        send_pair(make_pair(S_MAX, S_MIN, 0, 0, 0, 0, 0, 0));
        send_pair(noise_pair());
    endtask

    task automatic test_row_edges();
        curve_pair_t p;
        // End row zero: scan stops at row 0.
        set_scan(16'd5, 16'd0, 16'd1000);
        send_pair(make_pair(0, 0, ONE_PX, 0, 0, 0, 0, px(2)));
        // Start below end: nothing scanned.
        set_scan(16'd3, 16'd7, 16'hFFFF);
        p = crossing_pair();
        p.second = p.first;
        send_pair(p);
        // Single row.
        set_scan(16'd1234, 16'd1234, 16'hFFFF);
        send_pair(p);
        // Whole row space.
        set_scan(16'hFFFF, 16'h0000, 16'd1000);
        send_pair(crossing_pair());
        send_pair(make_pair(0, 0, ONE_PX, 0, 0, 0, 0, px(4095)));
    endtask

    task automatic test_limit_edges();
        curve_pair_t p;
        // Zero limit: even a zero gap is not below it.
        set_scan(16'd8, 16'd1, 16'd0);
        p = crossing_pair();
        p.second = p.first;
        send_pair(p);
        // One pixel is not below a one-pixel limit; one LSB less is.
        set_scan(16'd8, 16'd1, 16'd1);
        send_pair(make_pair(0, 0, 0, ONE_PX, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, ONE_PX - 1, 0, 0, 0, 0));
    endtask

    // Hold the result side off for a long stretch while items keep coming,
    // so the block backs up and stalls its input.
    task automatic test_backpressure();
        set_scan(16'd40, 16'd21, 16'd1500);
        tx_idle_on = 1'b0;
        rx_holdoff_req = 400;
        repeat (12) send_pair(crossing_pair());
        tx_idle_on = 1'b1;
    endtask

    // Phases of random register settings, each with a batch of items.
    task automatic test_random();
        int sent;
        int batch;
        int span;
        int top;
        int bottom;
        int pick;
        logic [LIMIT_W-1:0] limit_word;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                span = $urandom_range(1, 32);
            else if (pick <= 7)
                span = $urandom_range(33, 260);
            else
                span = 0;
            if (pick == 8)
            begin
                bottom = 0;
                top = $urandom_range(0, 200);
            end
            else if (pick == 9)
            begin
                top = $urandom_range(0, 4094);
                bottom = $urandom_range(top + 1, 4095);
            end
            else
            begin
                top = $urandom_range(span - 1, 4095);
                bottom = top - span + 1;
            end
            case ($urandom_range(0, 5))
                0:       limit_word = '0;
                1:       limit_word = '1;
                2:       limit_word = LIMIT_W'($urandom_range(1, 40));
                3, 4:    limit_word = LIMIT_W'($urandom_range(1, 2000));
                default: limit_word = LIMIT_W'($urandom);
            endcase
            set_scan({4'($urandom), 12'(top)}, {4'($urandom), 12'(bottom)}, limit_word);
            // Idle on some phases only, so back-to-back stretches occur too.
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            batch = $urandom_range(40, 90);
            for (int k = 0; k < batch && sent < RANDOM_ITEMS; k++)
            begin
                send_pair(random_pair());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, watchdog, result checker, test sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run as failed once the cycle counter reaches its bound, whatever the progress.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: stall for a random count, or for the requested one-shot holdoff, then take one
    // transaction and compare it field by field with the oldest expectation.
    initial
    begin : result_checker
        int    hold;
        meet_t want;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_holdoff_req > 0)
            begin
                hold = rx_holdoff_req;
                rx_holdoff_req = 0;
            end
            else
                hold = rx_idle_on ? $urandom_range(0, 11) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            if (pending_meets.size() == 0)
                report_mismatch("unexpected result", {63'd0, found}, 64'd0);
            else
            begin
                want = pending_meets.pop_front();
                if (found !== want.found)
                    report_mismatch("found", {63'd0, found}, {63'd0, want.found});
                if (meet_x !== want.x)
                    report_mismatch("meet_x", meet_x, want.x);
                if (meet_row !== want.row)
                    report_mismatch("meet_row", 64'(meet_row), 64'(want.row));
            end
            meets_checked++;
        end
    end

    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        first_cubic   = '0;
        first_square  = '0;
        first_linear  = '0;
        first_offset  = '0;
        second_cubic  = '0;
        second_square = '0;
        second_linear = '0;
        second_offset = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ties_and_midpoint();
        test_saturation();
        test_row_edges();
        test_limit_edges();
        test_backpressure();
        test_random();

        // Let the last results arrive, then allow a quiet tail.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
